/* rtl/sstp_pkg.sv */
// ----------------------------------------------------------------------------
// sstp_pkg
// Shared types and constants for the shadow-stack self-time profiler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sstp_pkg;

  // Hash mixer constants
  localparam logic [63:0] HASH_MULT    = 64'hff51afd7ed558ccd;
  localparam int unsigned HASH_SHIFT_A = 33;
  localparam int unsigned HASH_SHIFT_B = 29;

  // Steps of the start-slot reduction when the slot count is not a power of two
  localparam logic [6:0]  MOD_STEPS    = 7'd4;

  typedef enum logic [1:0] {
    REQ_ENTER = 2'd0,
    REQ_EXIT  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Shared 32x32 multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_H0   = 3'd1,
    MUL_H1   = 3'd2,
    MUL_H2   = 3'd3,
    MUL_R0   = 3'd4,
    MUL_R1   = 3'd5
  } mul_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ENTER,
    S_X_RD,
    S_X_CALC,
    S_X_PAR,
    S_X_PWR,
    S_M0,
    S_M1,
    S_M2,
    S_MOD_I,
    S_MOD,
    S_P_RD,
    S_P_CHK,
    S_R_RD,
    S_R_M0,
    S_R_M1,
    S_R_FIN,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    clr_step;
    logic    enter_do;
    logic    fr_latch;
    logic    fr_wr_par;
    mul_e    mul;
    logic    mod_init;
    logic    mod_step;
    logic    probe_hit_wr;
    logic    probe_next;
    logic    probe_full;
    logic    res_latch;
    logic    adj_calc;
    logic    set_status;
    status_e status;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic stack_full;
    logic stack_empty;
    logic fn_zero;
    logic mod_done;
    logic probe_hit;
    logic probe_last;
    logic full_mode;
    logic idx_ok;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/shadow_stack_self_time_profiler_unit.sv */
// ----------------------------------------------------------------------------
// shadow_stack_self_time_profiler_unit
// Function enter/exit self-time profiler with a shadow stack and a hashed
// slot table; APB register for per-call overhead.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  s_axis    in   tuser=req_type; tdata=func_address, timestamp, slot_index
//  m_axis    out  tuser=status; tdata=slot_valid, slot_func, slot_self,
//                 slot_adjusted, slot_calls, dropped_enters
//  apb       in   reg 0 @0x0: overhead_per_call[15:0]
//
//  One beat in flight at a time. An exit adds its total time to the parent
//  frame when there is one, then hashes the address and probes the table
//  from the start slot, which needs a remainder sequence when TABLE_SLOTS
//  is not a power of two; a zero address skips the table. An exit on an
//  empty stack and a readout with an out-of-range index return zero slot fields.
//  After reset the table is swept to zero; no beat is taken during the sweep.
//  A held result does not block the next beat; a finished beat waits in the
//  datapath until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shadow_stack_self_time_profiler_unit #(
  parameter int STACK_DEPTH = 1024,
  parameter int TABLE_SLOTS = 4096,
  parameter int ADDR_BITS   = 48
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [47:0] func_address, [111:48] timestamp, [123:112] slot_index
  input  wire logic [127:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [0] slot_valid, [48:1] slot_func, [112:49] slot_self,
  // [176:113] slot_adjusted, [240:177] slot_calls, [272:241] dropped_enters
  output logic [279:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]        m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  sstp_pkg::cmd_t cmd;
  sstp_pkg::sts_t sts;

  logic [15:0] ovh_q;
  logic        slot_valid;
  logic [47:0] slot_func;
  logic [63:0] slot_self, slot_adjusted, slot_calls;
  logic [31:0] dropped_enters;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovh_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      ovh_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, ovh_q};

  sstp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .req_i      (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  sstp_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .TABLE_SLOTS (TABLE_SLOTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_address_i   (s_axis_tdata[47:0]),
    .timestamp_i      (s_axis_tdata[111:48]),
    .slot_index_i     (s_axis_tdata[123:112]),
    .overhead_i       (ovh_q),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .status_o         (m_axis_tuser),
    .slot_valid_o     (slot_valid),
    .slot_func_o      (slot_func),
    .slot_self_o      (slot_self),
    .slot_adjusted_o  (slot_adjusted),
    .slot_calls_o     (slot_calls),
    .dropped_enters_o (dropped_enters)
  );

  assign m_axis_tdata = {7'd0, dropped_enters, slot_calls, slot_adjusted,
                         slot_self, slot_func, slot_valid};

endmodule

`default_nettype wire

/* rtl/sstp_ram.sv */
// ----------------------------------------------------------------------------
// sstp_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/sstp_ctrl.sv */
// ----------------------------------------------------------------------------
// sstp_ctrl
// Sequencer: table clear, stack push/pop, hash, probe and readout steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sstp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    req_i,
  input  sstp_pkg::sts_t     sts_i,
  output logic               in_ready_o,
  output sstp_pkg::cmd_t     cmd_o
);

  sstp_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sstp_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == sstp_pkg::S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      sstp_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = sstp_pkg::S_IDLE;
      end
      sstp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (sstp_pkg::req_e'(req_i))
            sstp_pkg::REQ_ENTER: state_d = sstp_pkg::S_ENTER;
            sstp_pkg::REQ_EXIT:  state_d = sstp_pkg::S_X_RD;
            sstp_pkg::REQ_READ:  state_d = sstp_pkg::S_R_RD;
            default:             state_d = sstp_pkg::S_DONE;
          endcase
        end
      end
      sstp_pkg::S_ENTER: begin
        cmd_o.enter_do = 1'b1;
        if (sts_i.stack_full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = sstp_pkg::ST_DROP;
        end
        state_d = sstp_pkg::S_DONE;
      end
      sstp_pkg::S_X_RD: begin
        if (sts_i.stack_empty) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = sstp_pkg::ST_EMPTY;
          state_d          = sstp_pkg::S_DONE;
        end else begin
          state_d = sstp_pkg::S_X_CALC;
        end
      end
      sstp_pkg::S_X_CALC: begin
        cmd_o.fr_latch = 1'b1;
        state_d        = sstp_pkg::S_X_PAR;
      end
      sstp_pkg::S_X_PAR: begin
        // parent frame read is in flight
        if (!sts_i.stack_empty) begin
          state_d = sstp_pkg::S_X_PWR;
        end else if (sts_i.fn_zero) begin
          state_d = sstp_pkg::S_DONE;
        end else begin
          state_d = sstp_pkg::S_M0;
        end
      end
      sstp_pkg::S_X_PWR: begin
        cmd_o.fr_wr_par = 1'b1;
        state_d = sts_i.fn_zero ? sstp_pkg::S_DONE : sstp_pkg::S_M0;
      end
      sstp_pkg::S_M0: begin
        cmd_o.mul = sstp_pkg::MUL_H0;
        state_d   = sstp_pkg::S_M1;
      end
      sstp_pkg::S_M1: begin
        cmd_o.mul = sstp_pkg::MUL_H1;
        state_d   = sstp_pkg::S_M2;
      end
      sstp_pkg::S_M2: begin
        cmd_o.mul = sstp_pkg::MUL_H2;
        state_d   = sstp_pkg::S_MOD_I;
      end
      sstp_pkg::S_MOD_I: begin
        cmd_o.mod_init = 1'b1;
        state_d        = sstp_pkg::S_MOD;
      end
      sstp_pkg::S_MOD: begin
        if (sts_i.mod_done) begin
          state_d = sstp_pkg::S_P_RD;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      sstp_pkg::S_P_RD: begin
        state_d = sstp_pkg::S_P_CHK;
      end
      sstp_pkg::S_P_CHK: begin
        if (sts_i.probe_hit) begin
          cmd_o.probe_hit_wr = 1'b1;
          cmd_o.set_status   = 1'b1;
          cmd_o.status       = sts_i.full_mode ? sstp_pkg::ST_FULL : sstp_pkg::ST_OK;
          state_d            = sstp_pkg::S_DONE;
        end else if (sts_i.probe_last) begin
          cmd_o.probe_full = 1'b1;
          state_d          = sstp_pkg::S_P_RD;
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d          = sstp_pkg::S_P_RD;
        end
      end
      sstp_pkg::S_R_RD: begin
        state_d = sts_i.idx_ok ? sstp_pkg::S_R_M0 : sstp_pkg::S_DONE;
      end
      sstp_pkg::S_R_M0: begin
        cmd_o.res_latch = 1'b1;
        cmd_o.mul       = sstp_pkg::MUL_R0;
        state_d         = sstp_pkg::S_R_M1;
      end
      sstp_pkg::S_R_M1: begin
        cmd_o.mul = sstp_pkg::MUL_R1;
        state_d   = sstp_pkg::S_R_FIN;
      end
      sstp_pkg::S_R_FIN: begin
        cmd_o.adj_calc = 1'b1;
        state_d        = sstp_pkg::S_DONE;
      end
      sstp_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sstp_pkg::S_IDLE;
        end
      end
      default: state_d = sstp_pkg::S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sstp_dp.sv */
// ----------------------------------------------------------------------------
// sstp_dp
// Datapath: frame stack RAM, slot table RAM, hash, remainder, probe and
// readout arithmetic, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sstp_dp #(
  parameter int STACK_DEPTH = 1024,
  parameter int TABLE_SLOTS = 4096,
  parameter int ADDR_BITS   = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  sstp_pkg::cmd_t   cmd_i,
  output sstp_pkg::sts_t   sts_o,
  input  wire logic [47:0] func_address_i,
  input  wire logic [63:0] timestamp_i,
  input  wire logic [11:0] slot_index_i,
  input  wire logic [15:0] overhead_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       status_o,
  output logic             slot_valid_o,
  output logic [47:0]      slot_func_o,
  output logic [63:0]      slot_self_o,
  output logic [63:0]      slot_adjusted_o,
  output logic [63:0]      slot_calls_o,
  output logic [31:0]      dropped_enters_o
);

  localparam int AW   = (ADDR_BITS < 48) ? ADDR_BITS : 48;
  localparam int FW   = $clog2(STACK_DEPTH);
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int TW   = $clog2(TABLE_SLOTS);
  localparam int EW   = AW + 128;
  localparam bit POW2 = (TABLE_SLOTS == (1 << TW));
  localparam logic [TW-1:0] SLOT_LAST = TW'(TABLE_SLOTS - 1);

  // Start-slot reduction constants: 2^(16k) mod slots, and a 2^32 reciprocal
  localparam logic [63:0] N64   = 64'(TABLE_SLOTS);
  localparam logic [15:0] R1    = 16'((64'd1 << 16) % N64);
  localparam logic [15:0] R2    = 16'((64'd1 << 32) % N64);
  localparam logic [15:0] R3    = 16'((64'd1 << 48) % N64);
  localparam logic [28:0] RECIP = 29'((64'd1 << 32) / N64);
  localparam logic [16:0] NK    = 17'(TABLE_SLOTS);
  localparam logic [18:0] N1    = 19'(TABLE_SLOTS);
  localparam logic [18:0] N2    = 19'(2 * TABLE_SLOTS);
  localparam logic [18:0] N3    = 19'(3 * TABLE_SLOTS);
  localparam logic [18:0] N4    = 19'(4 * TABLE_SLOTS);
  localparam logic [18:0] N5    = 19'(5 * TABLE_SLOTS);

  // Latched request
  logic [AW-1:0] addr_q;
  logic [63:0]   ts_q;
  logic          idx_ok_q;

  // Stack state
  logic [DW-1:0] depth_q;
  logic [DW-1:0] dm1;
  logic [31:0]   ovf_q;
  logic [AW-1:0] fn_q;
  logic [63:0]   total_q;
  logic [63:0]   self_q;

  // Hash and probe state
  logic [63:0]   hash_q;
  logic [63:0]   acc_q;
  logic [63:0]   h2;
  logic [63:0]   msh_q;
  logic [6:0]    mcnt_q;
  logic [31:0]   fp1, fp2, fp3;
  logic [33:0]   fold_d, fold_q;
  logic [62:0]   qp;
  logic [30:0]   qe_q;
  logic [47:0]   qn;
  logic [18:0]   r0_q, rfix;
  logic [TW-1:0] slot_q;
  logic [TW-1:0] pcnt_q;
  logic          full_q;
  logic [TW-1:0] clr_q;

  // Readout arithmetic
  logic [96:0]   ovp_q;
  logic          sat;

  // Result being built and output register
  logic [1:0]    res_status_q;
  logic          res_valid_q;
  logic [47:0]   res_func_q;
  logic [63:0]   res_self_q;
  logic [63:0]   res_adj_q;
  logic [63:0]   res_calls_q;
  logic          out_valid_q;

  // Memories
  logic          fr_we;
  logic [FW-1:0] fr_addr;
  logic [EW-1:0] fr_wdata, fr_rdata;
  logic          tb_we;
  logic [TW-1:0] tb_addr;
  logic [EW-1:0] tb_wdata, tb_rdata;

  logic [AW-1:0] fr_func, rf;
  logic [63:0]   fr_start, fr_ch, rself, rcalls;
  logic [63:0]   fr_total;
  logic [63:0]   hin;

  // Multiplier
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;

  assign dm1      = depth_q - 1'b1;
  assign fr_func  = fr_rdata[AW-1:0];
  assign fr_start = fr_rdata[AW+63:AW];
  assign fr_ch    = fr_rdata[AW+127:AW+64];
  assign rf       = tb_rdata[AW-1:0];
  assign rself    = tb_rdata[AW+63:AW];
  assign rcalls   = tb_rdata[AW+127:AW+64];
  assign fr_total = ts_q - fr_start;
  assign hin      = 64'(fr_func);
  assign h2       = acc_q ^ (acc_q >> sstp_pkg::HASH_SHIFT_B);

  // Frame stack port: push writes at depth, pops read below it
  assign fr_we    = (cmd_i.enter_do && !sts_o.stack_full) || cmd_i.fr_wr_par;
  assign fr_addr  = cmd_i.enter_do ? depth_q[FW-1:0] : dm1[FW-1:0];
  assign fr_wdata = cmd_i.enter_do ? {64'd0, ts_q, addr_q}
                                   : {fr_ch + total_q, fr_start, fr_func};

  sstp_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_frames (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .addr_i  (fr_addr),
    .wdata_i (fr_wdata),
    .rdata_o (fr_rdata)
  );

  // Slot table port: clear sweep or probe / readout slot
  assign tb_we    = cmd_i.clr_step || cmd_i.probe_hit_wr;
  assign tb_addr  = cmd_i.clr_step ? clr_q : slot_q;
  assign tb_wdata = cmd_i.clr_step ? '0
                  : {rcalls + 64'd1, rself + self_q, full_q ? rf : fn_q};

  sstp_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .addr_i  (tb_addr),
    .wdata_i (tb_wdata),
    .rdata_o (tb_rdata)
  );

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul)
      sstp_pkg::MUL_H0: begin
        mul_a = hash_q[31:0];
        mul_b = sstp_pkg::HASH_MULT[31:0];
      end
      sstp_pkg::MUL_H1: begin
        mul_a = hash_q[31:0];
        mul_b = sstp_pkg::HASH_MULT[63:32];
      end
      sstp_pkg::MUL_H2: begin
        mul_a = hash_q[63:32];
        mul_b = sstp_pkg::HASH_MULT[31:0];
      end
      sstp_pkg::MUL_R0: begin
        mul_a = rcalls[31:0];
        mul_b = {16'd0, overhead_i};
      end
      sstp_pkg::MUL_R1: begin
        mul_a = res_calls_q[63:32];
        mul_b = {16'd0, overhead_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Remainder: fold 16-bit chunks, estimate the quotient, fix up by up to 4N
  assign fp1    = {16'd0, msh_q[31:16]} * {16'd0, R1};
  assign fp2    = {16'd0, msh_q[47:32]} * {16'd0, R2};
  assign fp3    = {16'd0, msh_q[63:48]} * {16'd0, R3};
  assign fold_d = {2'b0, fp1} + {2'b0, fp2} + {2'b0, fp3} + {18'd0, msh_q[15:0]};
  assign qp     = {29'd0, fold_q} * {34'd0, RECIP};
  assign qn     = {17'd0, qe_q} * {31'd0, NK};
  assign rfix   = (r0_q >= N4) ? r0_q - N4
                : (r0_q >= N3) ? r0_q - N3
                : (r0_q >= N2) ? r0_q - N2
                : (r0_q >= N1) ? r0_q - N1 : r0_q;

  assign sat = |ovp_q[96:64];

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      ovf_q       <= '0;
      clr_q       <= '0;
      mcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.enter_do) begin
        if (sts_o.stack_full) ovf_q <= ovf_q + 32'd1;
        else                  depth_q <= depth_q + 1'b1;
      end
      if (cmd_i.fr_latch) depth_q <= dm1;
      if (cmd_i.mod_init) begin
        mcnt_q <= POW2 ? 7'd0 : sstp_pkg::MOD_STEPS;
      end else if (cmd_i.mod_step) begin
        mcnt_q <= mcnt_q - 7'd1;
      end
      if (cmd_i.out_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q       <= func_address_i[AW-1:0];
      ts_q         <= timestamp_i;
      slot_q       <= TW'(slot_index_i);
      idx_ok_q     <= ({20'd0, slot_index_i} < 32'(TABLE_SLOTS));
      res_status_q <= sstp_pkg::ST_OK;
      res_valid_q  <= 1'b0;
      res_func_q   <= '0;
      res_self_q   <= '0;
      res_adj_q    <= '0;
      res_calls_q  <= '0;
    end
    // pop: time split of the top frame
    if (cmd_i.fr_latch) begin
      fn_q    <= fr_func;
      total_q <= fr_total;
      self_q  <= (fr_ch > fr_total) ? 64'd0 : fr_total - fr_ch;
      hash_q  <= hin ^ (hin >> sstp_pkg::HASH_SHIFT_A);
    end
    // 64x64 low product in three partial steps, then readout product
    case (cmd_i.mul)
      sstp_pkg::MUL_H0: acc_q <= prod;
      sstp_pkg::MUL_H1: acc_q <= acc_q + {prod[31:0], 32'd0};
      sstp_pkg::MUL_H2: acc_q <= acc_q + {prod[31:0], 32'd0};
      sstp_pkg::MUL_R0: acc_q <= prod;
      sstp_pkg::MUL_R1: ovp_q <= {33'd0, acc_q} + {1'b0, prod, 32'd0};
      default: ;
    endcase
    // start slot = hash mod slots; a mask for a power of two, else four steps
    if (cmd_i.mod_init) begin
      msh_q  <= h2;
      pcnt_q <= '0;
      full_q <= 1'b0;
      if (POW2) slot_q <= h2[TW-1:0];
    end
    if (cmd_i.mod_step) begin
      case (mcnt_q)
        7'd4:    fold_q <= fold_d;
        7'd3:    qe_q   <= qp[62:32];
        7'd2:    r0_q   <= fold_q[18:0] - qn[18:0];
        7'd1:    slot_q <= rfix[TW-1:0];
        default: ;
      endcase
    end
    // linear probe
    if (cmd_i.probe_next) begin
      slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
      pcnt_q <= pcnt_q + 1'b1;
    end
    if (cmd_i.probe_full) begin
      full_q <= 1'b1;
      slot_q <= '0;
    end
    // readout
    if (cmd_i.res_latch) begin
      res_func_q  <= 48'(rf);
      res_self_q  <= rself;
      res_calls_q <= rcalls;
      res_valid_q <= (rf != '0) && (rcalls != 64'd0);
    end
    if (cmd_i.adj_calc) begin
      res_adj_q <= (!sat && res_self_q > ovp_q[63:0]) ? res_self_q - ovp_q[63:0] : 64'd0;
    end
    if (cmd_i.set_status) res_status_q <= cmd_i.status;
    if (cmd_i.out_load) begin
      status_o         <= res_status_q;
      slot_valid_o     <= res_valid_q;
      slot_func_o      <= res_func_q;
      slot_self_o      <= res_self_q;
      slot_adjusted_o  <= res_adj_q;
      slot_calls_o     <= res_calls_q;
      dropped_enters_o <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to controller
  always_comb begin
    sts_o.clr_last    = (clr_q == SLOT_LAST);
    sts_o.stack_full  = (depth_q >= DW'(STACK_DEPTH));
    sts_o.stack_empty = (depth_q == '0);
    sts_o.fn_zero     = (fn_q == '0);
    sts_o.mod_done    = (mcnt_q == 7'd0);
    sts_o.probe_hit   = full_q || (rf == fn_q) || (rf == '0);
    sts_o.probe_last  = (pcnt_q == SLOT_LAST);
    sts_o.full_mode   = full_q;
    sts_o.idx_ok      = idx_ok_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mcnt_q == 7'd1) |-> (r0_q < N5))
    else $error("remainder estimate out of range");

  a_ovf_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q != $past(ovf_q)) |-> $past(cmd_i.enter_do && sts_o.stack_full))
    else $error("overflow count moved without a dropped enter");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.out_load))
    else $error("result shown without a load");

endmodule

`default_nettype wire

/* tb/shadow_stack_self_time_profiler_unit_checker.sv */
// ----------------------------------------------------------------------------
// shadow_stack_self_time_profiler_unit_checker
// Watches the event, result and register channels of the profiler, keeps its
// own copy of the shadow stack and slot table, predicts one result beat per
// accepted event beat and compares result beats against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shadow_stack_self_time_profiler_unit_checker
  import sstp_pkg::*;
#(
  parameter logic [2:0] OVERHEAD_ADDR = 3'd0
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [279:0] m_axis_tdata,
  input  wire logic [1:0]   m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  input  wire logic         pready,
  output int                fail_count,
  output int                pending
);

  localparam int FRAMES = 1024;
  localparam int SLOTS  = 4096;

  typedef struct {
    status_e     status;
    logic        valid;
    logic [47:0] func;
    logic [63:0] self_cyc;
    logic [63:0] adjusted;
    logic [63:0] calls;
    logic [31:0] dropped;
  } profile_result_t;

  // shadow stack and slot table copies
  logic [47:0] frame_fn    [FRAMES];
  logic [63:0] frame_t0    [FRAMES];
  logic [63:0] frame_kids  [FRAMES];
  int          stack_level = 0;
  logic [31:0] drop_total  = '0;
  logic [47:0] slot_fn     [SLOTS];
  logic [63:0] slot_cycles [SLOTS];
  logic [63:0] slot_count  [SLOTS];
  logic [15:0] overhead    = '0;

  profile_result_t expected_results[$];

  initial begin
    fail_count = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_fn[i]     = '0;
      slot_cycles[i] = '0;
      slot_count[i]  = '0;
    end
  end

  assign pending = expected_results.size();

  // charge one finished frame to its function's slot
  function automatic status_e charge_slot(logic [47:0] fn, logic [63:0] self_cyc);
    logic [63:0] h;
    int          k;
    int          start;
    h = {16'd0, fn};
    h = h ^ (h >> HASH_SHIFT_A);
    h = h * HASH_MULT;
    h = h ^ (h >> HASH_SHIFT_B);
    start = int'(h[11:0]);
    for (int n = 0; n < SLOTS; n++) begin
      k = (start + n) % SLOTS;
      if (slot_fn[k] == fn || slot_fn[k] == '0) begin
        slot_fn[k]     = fn;
        slot_cycles[k] += self_cyc;
        slot_count[k]  += 64'd1;
        return ST_OK;
      end
    end
    // table full: slot 0 keeps its address
    slot_cycles[0] += self_cyc;
    slot_count[0]  += 64'd1;
    return ST_FULL;
  endfunction

  function automatic profile_result_t predict_profile_event(req_e req, logic [127:0] data);
    profile_result_t r;
    logic [47:0]     addr;
    logic [63:0]     ts;
    logic [11:0]     idx;
    logic [63:0]     total;
    logic [63:0]     self_cyc;
    logic [127:0]    prod;
    addr = data[47:0];
    ts   = data[111:48];
    idx  = data[123:112];
    r.status = ST_OK; r.valid = 1'b0; r.func = '0;
    r.self_cyc = '0; r.adjusted = '0; r.calls = '0;
    case (req)
      REQ_ENTER: begin
        if (stack_level >= FRAMES) begin
          drop_total += 32'd1;
          r.status = ST_DROP;
        end else begin
          frame_fn[stack_level]   = addr;
          frame_t0[stack_level]   = ts;
          frame_kids[stack_level] = '0;
          stack_level++;
        end
      end
      REQ_EXIT: begin
        if (stack_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_level--;
          total    = ts - frame_t0[stack_level];
          self_cyc = total - frame_kids[stack_level];
          if (self_cyc > total) self_cyc = '0;
          if (frame_fn[stack_level] != '0)
            r.status = charge_slot(frame_fn[stack_level], self_cyc);
          if (stack_level > 0) frame_kids[stack_level-1] += total;
        end
      end
      REQ_READ: begin
        r.func     = slot_fn[idx];
        r.self_cyc = slot_cycles[idx];
        r.calls    = slot_count[idx];
        r.valid    = (r.func != '0) && (r.calls != '0);
        prod       = {64'd0, r.calls} * {112'd0, overhead};
        if (prod[127:64] == '0 && r.self_cyc > prod[63:0])
          r.adjusted = r.self_cyc - prod[63:0];
      end
      default: ;
    endcase
    r.dropped = drop_total;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // event beats feed the predictor, result beats are checked in order
  always @(posedge clk_i) begin
    profile_result_t e;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == OVERHEAD_ADDR)
        overhead <= pwdata[15:0];
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_profile_event(req_e'(s_axis_tuser), s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, actual %h %h",
                   $time, m_axis_tuser, m_axis_tdata);
        end else begin
          e = expected_results.pop_front();
          check_field("status", 64'(e.status), 64'(m_axis_tuser));
          check_field("slot_valid", 64'(e.valid), 64'(m_axis_tdata[0]));
          check_field("slot_func", 64'(e.func), 64'(m_axis_tdata[48:1]));
          check_field("slot_self", e.self_cyc, m_axis_tdata[112:49]);
          check_field("slot_adjusted", e.adjusted, m_axis_tdata[176:113]);
          check_field("slot_calls", e.calls, m_axis_tdata[240:177]);
          check_field("dropped_enters", 64'(e.dropped), 64'(m_axis_tdata[272:241]));
        end
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb_shadow_stack_self_time_profiler_unit.sv */
// ----------------------------------------------------------------------------
// tb_shadow_stack_self_time_profiler_unit
// Drives enter, exit and readout beats into the profiler with random idling
// on both sides, writes the overhead register between phases, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_shadow_stack_self_time_profiler_unit;
  import sstp_pkg::*;

  localparam logic [2:0] OVERHEAD_ADDR = 3'd0;
  localparam int         CYCLE_LIMIT   = 8000000;
  localparam int         POOL_SIZE     = 48;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [279:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count;
  int           pending;

  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           depth_mirror = 0;
  int           cycles = 0;
  logic [63:0]  now_ts = 64'd1000;
  logic [47:0]  func_pool [POOL_SIZE];

  shadow_stack_self_time_profiler_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  shadow_stack_self_time_profiler_unit_checker #(.OVERHEAD_ADDR(OVERHEAD_ADDR)) u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("shadow_stack_self_time_profiler_unit regression: fail");
      $finish;
    end
  end

  // home slot of a function, used to aim readouts at live entries
  function automatic logic [11:0] home_slot(logic [47:0] fn);
    logic [63:0] h;
    h = {16'd0, fn};
    h = h ^ (h >> HASH_SHIFT_A);
    h = h * HASH_MULT;
    h = h ^ (h >> HASH_SHIFT_B);
    return h[11:0];
  endfunction

  task automatic send_event(req_e req, logic [47:0] addr, logic [63:0] ts, logic [11:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {4'd0, idx, ts, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    if (req == REQ_ENTER && depth_mirror < 1024) depth_mirror++;
    if (req == REQ_EXIT && depth_mirror > 0) depth_mirror--;
  endtask

  // stop sending and let every expected beat come back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_overhead(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OVERHEAD_ADDR;
    pwdata  <= {16'($urandom_range(65535)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [63:0] next_ts;
    if ($urandom_range(99) < 3) now_ts = {$urandom, $urandom};
    else now_ts = now_ts + 64'($urandom_range(1, 300));
    return now_ts;
  endfunction

  task automatic random_events(int count);
    int          r;
    req_e        req;
    logic [47:0] addr;
    logic [11:0] idx;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 10) req = REQ_READ;
      else if (r < 12) req = REQ_NONE;
      else if (depth_mirror < 3) req = ($urandom_range(9) < 8) ? REQ_ENTER : REQ_EXIT;
      else if (depth_mirror > 30) req = ($urandom_range(9) < 7) ? REQ_EXIT : REQ_ENTER;
      else req = (r < 56) ? REQ_ENTER : REQ_EXIT;
      r = $urandom_range(99);
      if (r < 2) addr = '0;
      else if (r < 8) addr = 48'({$urandom, $urandom});
      else addr = func_pool[$urandom_range(POOL_SIZE-1)];
      if (req == REQ_READ && $urandom_range(99) < 65)
        idx = home_slot(func_pool[$urandom_range(POOL_SIZE-1)]);
      else idx = 12'($urandom);
      send_event(req, addr, next_ts(), idx);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      func_pool[i] = 48'({$urandom, $urandom});
      if (func_pool[i] == '0) func_pool[i] = 48'h1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_overhead(16'd0);

    // directed: empty exit, idle type, timestamp wrap, zero address,
    // self-time clamp, ignored exit address, edge slots
    send_event(REQ_EXIT, '1, 64'd5, '0);
    send_event(REQ_NONE, '1, '1, '1);
    send_event(REQ_READ, '0, '0, 12'd0);
    send_event(REQ_READ, '0, '0, 12'hFFF);
    send_event(REQ_ENTER, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, '0);
    send_event(REQ_ENTER, 48'd0, 64'hFFFF_FFFF_FFFF_FFF8, '0);
    send_event(REQ_EXIT, 48'h1234, 64'd20, '0);
    send_event(REQ_EXIT, '1, 64'd40, '0);
    send_event(REQ_ENTER, func_pool[0], 64'd100, '0);
    send_event(REQ_ENTER, func_pool[1], 64'd100, '0);
    send_event(REQ_EXIT, '0, 64'd1000, '0);
    send_event(REQ_EXIT, '0, 64'd500, '0);
    send_event(REQ_ENTER, func_pool[0], 64'd2000, '1);
    send_event(REQ_EXIT, func_pool[5], 64'd2600, '1);
    send_event(REQ_READ, '0, '0, home_slot(48'hFFFF_FFFF_FFFF));
    send_event(REQ_READ, '0, '0, home_slot(func_pool[0]));
    send_event(REQ_READ, '0, '0, home_slot(func_pool[1]));
    drain();
    write_overhead(16'hFFFF);
    send_event(REQ_READ, '0, '0, home_slot(func_pool[0]));
    send_event(REQ_READ, '0, '0, home_slot(func_pool[1]));
    send_event(REQ_READ, '0, '0, home_slot(48'hFFFF_FFFF_FFFF));
    drain();

    // random phases with different idling
    write_overhead(16'd1);
    random_events(345);
    drain();
    write_overhead(16'($urandom));
    send_idle_pct = 54;
    random_events(345);
    drain();
    write_overhead(16'd7);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    random_events(345);
    drain();
    write_overhead(16'hFFFF);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    random_events(345);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;

    if (fail_count == 0 && pending == 0) begin
      $display("shadow_stack_self_time_profiler_unit regression: pass");
    end else begin
      $display("shadow_stack_self_time_profiler_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
